>>> rtl/url_percent_codec_top_assert.svh
// assertion macros for the url percent codec
`ifndef URL_PERCENT_CODEC_TOP_ASSERT_SVH
`define URL_PERCENT_CODEC_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/upc_pkg.sv
package upc_pkg;

    // character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // register map
    localparam logic REG_DECODE_MODE = 1'b0;

    // decode escape phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    // results caused by one input byte
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } run_t;

    // queue status seen by front, back and top
    typedef struct packed {
        logic                empty;
        logic                full;
        logic [QUEUE_CW-1:0] count;
    } queue_status_t;

    // hex digit of either case: {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // bytes that encoding passes through
    function automatic logic keep_plain(input logic [7:0] c);
        logic k;
        k = (c == CH_STAR) || (c == CH_DASH) || (c == CH_DOT) || (c == CH_UNDER)
            || (c >= 8'h30 && c <= 8'h39)
            || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
        return k;
    endfunction

    // upper-case hex character of a nibble
    function automatic logic [7:0] hex_upper(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'b0, v};
        end else begin
            r = 8'h37 + {4'b0, v};
        end
        return r;
    endfunction

endpackage

>>> rtl/url_percent_codec_top.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------
// input    | in_valid / in_stall   | in_byte, end_of_text
// output   | out_valid / out_stall | out_byte, last_of_run
// config   | psel/penable/pwrite   | paddr, pwdata, prdata
//
// the output side gives one byte per cycle from its serializer while
// out_stall is low; an input byte is taken every cycle while the run queue
// is not full, and a run of three results is sent as three bytes, so once
// the two-entry run queue is full the input is stalled until a run pops.
// the first result of a byte goes through the run queue to the output register.
// rst_n clears the mode to encode, the escape state, queue and output.
module url_percent_codec_top
    import upc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);

    logic          mode_reg;
    logic          cfg_write;
    logic          push;
    logic          pop;
    run_t          push_run;
    run_t          head_run;
    queue_status_t q_status;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DECODE_MODE);
    assign prdata    = (paddr[2] == REG_DECODE_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
        end else if (cfg_write) begin
            mode_reg <= pwdata[0];
        end
    end

    // classifier
    upc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .decode_mode (mode_reg),
        .cfg_clear   (cfg_write),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .q_status    (q_status),
        .in_stall    (in_stall),
        .push        (push),
        .push_run    (push_run)
    );

    // run queue
    upc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head_run (head_run),
        .status   (q_status)
    );

    // serializer
    upc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_run    (head_run),
        .q_status    (q_status),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // checks
    `include "url_percent_codec_top_assert.svh"

    `UPC_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= QUEUE_CW'(QUEUE_DEPTH), "queue overflow")
    `UPC_ASSERT_NEXT(a_encode_queued, in_valid && !in_stall && !mode_reg, !q_status.empty, "encoded run lost")
    `UPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled output changed")

endmodule

>>> rtl/upc_front.sv
module upc_front
    import upc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          decode_mode,
    input  logic          cfg_clear,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          end_of_text,
    input  queue_status_t q_status,
    output logic          in_stall,
    output logic          push,
    output run_t          push_run
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    logic [3:0][7:0] cand;
    logic [2:0]      ccnt;
    logic            do_idle;
    logic [4:0]      cv;
    logic [4:0]      hv;
    logic            in_accept;

    assign in_stall  = q_status.full;
    assign in_accept = in_valid && !q_status.full;

    // classify the byte and build its run of results
    always_comb
    begin
        cand       = '0;
        ccnt       = 3'd0;
        do_idle    = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        cv         = hex_value(in_byte);
        hv         = hex_value(held_reg);
        if (!decode_mode) begin
            if (keep_plain(in_byte)) begin
                cand[0] = in_byte;
                ccnt    = 3'd1;
            end else begin
                cand[0] = CH_PERCENT;
                cand[1] = hex_upper(in_byte[7:4]);
                cand[2] = hex_upper(in_byte[3:0]);
                ccnt    = 3'd3;
            end
        end else begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (cv[4]) begin
                        held_next  = in_byte;
                        phase_next = PH_DIGIT;
                    end else begin
                        cand[0]    = CH_PERCENT;
                        ccnt       = 3'd1;
                        phase_next = PH_IDLE;
                        do_idle    = 1'b1;
                    end
                end
                PH_DIGIT:
                begin
                    if (cv[4] && hv[4]) begin
                        cand[0]    = {hv[3:0], cv[3:0]};
                        ccnt       = 3'd1;
                        phase_next = PH_IDLE;
                        held_next  = 8'h00;
                    end else begin
                        cand[0]    = CH_PERCENT;
                        cand[1]    = held_reg;
                        ccnt       = 3'd2;
                        phase_next = PH_IDLE;
                        held_next  = 8'h00;
                        do_idle    = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    do_idle    = 1'b1;
                end
            endcase
            // byte handled with no escape pending
            if (do_idle) begin
                if (in_byte == CH_PERCENT) begin
                    phase_next = PH_PCT;
                end else begin
                    cand[ccnt[1:0]] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
                    ccnt            = ccnt + 3'd1;
                end
            end
            // flush a pending escape at end of text
            if (end_of_text) begin
                if (phase_next == PH_PCT) begin
                    cand[ccnt[1:0]] = CH_PERCENT;
                    ccnt            = ccnt + 3'd1;
                end else if (phase_next == PH_DIGIT) begin
                    cand[ccnt[1:0]] = CH_PERCENT;
                    ccnt            = ccnt + 3'd1;
                    cand[ccnt[1:0]] = held_next;
                    ccnt            = ccnt + 3'd1;
                end
                phase_next = PH_IDLE;
                held_next  = 8'h00;
            end
        end
    end

    // at most three results per byte
    always_comb
    begin
        push_run.bytes = cand[2:0];
        push_run.count = (ccnt > 3'd3) ? 2'd3 : ccnt[1:0];
        push           = in_accept && (ccnt != 3'd0);
    end

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end else if (cfg_clear) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

>>> rtl/upc_queue.sv
module upc_queue
    import upc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  run_t          push_run,
    input  logic          pop,
    output run_t          head_run,
    output queue_status_t status
);

    run_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.count = count_reg;
    assign head_run     = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

endmodule

>>> rtl/upc_back.sv
module upc_back
    import upc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  run_t          head_run,
    input  queue_status_t q_status,
    output logic          pop,
    input  logic          out_stall,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          last_of_run
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

    // step through the head run one byte per transaction
    assign load   = !q_status.empty && (!valid_reg || !out_stall);
    assign at_end = (idx_reg == head_run.count - 2'd1);
    assign pop    = load && at_end;

    // index within the head run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg <= head_run.bytes[idx_reg];
            last_reg <= at_end;
        end
    end

endmodule

>>> sim/url_percent_codec_top_tb.sv
`timescale 1ns / 1ps

module url_percent_codec_top_tb;
    import upc_pkg::*;

    // register map and mode values
    localparam logic [2:0] ADDR_MODE  = 3'(REG_DECODE_MODE) * 3'd4;
    localparam logic [2:0] ADDR_SPARE = 3'd4;
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // run shape
    localparam int N_DIRECTED    = 25;
    localparam int RANDOM_ITEMS  = 185;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;

    // bytes around the edges of the pass-through classes
    localparam logic [15:0][7:0] ENC_EDGES = {
        8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A, 8'h5B,
        8'h60, 8'h61, 8'h7A, 8'h7B, 8'h2C, 8'h7F, 8'h80, 8'h5E
    };

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_DIGIT
    } esc_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    // one row of the directed table; chars holds the first result in its top byte
    typedef struct packed {
        logic        wr_mode;
        logic        mode;
        logic [7:0]  ch;
        logic        eot;
        logic        typed;
        logic [1:0]  n;
        logic [23:0] chars;
    } row_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte     = '0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;

    // codec state as the testbench sees it
    logic       mode_q = MODE_ENCODE;
    esc_t       esc_q  = ESC_NONE;
    logic [7:0] held_q = '0;
    logic [7:0] run_q[$];

    out_char_t  expected_chars[$];
    out_char_t  head;

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mode_writes   = 0;
    int input_holds   = 0;
    int phases        = 0;
    int burst_left    = 0;
    int hold_reqs     = 0;
    int cycles        = 0;
    logic idle_on     = 1'b1;

    url_percent_codec_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hex digit of either case: {valid, value}
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
        return 5'b0;
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        return (c == CH_STAR) || (c == CH_DASH) || (c == CH_DOT) || (c == CH_UNDER)
            || (c >= "0" && c <= "9") || (c >= "A" && c <= "Z")
            || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'("0" + v) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] random_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10) return 8'("0" + v);
        return ($urandom_range(0, 1) != 0) ? 8'("A" + v - 10) : 8'("a" + v - 10);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        logic [4:0] d;
        do
        begin
            c = 8'($urandom_range(0, 255));
            d = digit_value(c);
        end while (d[4]);
        return c;
    endfunction

    // byte seen with no escape pending
    task automatic decode_plain(input logic [7:0] c);
        if (c == CH_PERCENT)
            esc_q = ESC_PCT;
        else
            run_q.push_back((c == CH_PLUS) ? CH_SPACE : c);
    endtask

    // work out the run of output bytes caused by one input byte
    task automatic convert_char(input logic [7:0] c, input logic eot);
        logic [4:0] v;
        logic [4:0] h;
        run_q.delete();
        if (mode_q == MODE_ENCODE)
        begin
            if (passes_plain(c))
            begin
                run_q.push_back(c);
            end
            else
            begin
                run_q.push_back(CH_PERCENT);
                run_q.push_back(nibble_char(c[7:4]));
                run_q.push_back(nibble_char(c[3:0]));
            end
        end
        else
        begin
            v = digit_value(c);
            h = digit_value(held_q);
            case (esc_q)
                ESC_PCT:
                begin
                    if (v[4])
                    begin
                        held_q = c;
                        esc_q  = ESC_DIGIT;
                    end
                    else
                    begin
                        run_q.push_back(CH_PERCENT);
                        esc_q = ESC_NONE;
                        decode_plain(c);
                    end
                end
                ESC_DIGIT:
                begin
                    if (v[4] && h[4])
                    begin
                        run_q.push_back({h[3:0], v[3:0]});
                    end
                    else
                    begin
                        run_q.push_back(CH_PERCENT);
                        run_q.push_back(held_q);
                    end
                    esc_q  = ESC_NONE;
                    held_q = '0;
                    if (!(v[4] && h[4]))
                        decode_plain(c);
                end
                default:
                begin
                    esc_q = ESC_NONE;
                    decode_plain(c);
                end
            endcase
            // flush a pending escape at end of text
            if (eot)
            begin
                if (esc_q == ESC_PCT)
                begin
                    run_q.push_back(CH_PERCENT);
                end
                else if (esc_q == ESC_DIGIT)
                begin
                    run_q.push_back(CH_PERCENT);
                    run_q.push_back(held_q);
                end
                esc_q  = ESC_NONE;
                held_q = '0;
            end
        end
    endtask

    // queue the expected run, then offer the byte until the block takes it
    task automatic offer(input logic [7:0] c, input logic eot, input logic typed = 1'b0,
                         input logic [1:0] n_typed = 2'd0, input logic [23:0] chars = '0);
        int i;
        out_char_t e;
        convert_char(c, eot);
        if (typed)
        begin
            for (i = 0; i < n_typed; i++)
            begin
                e.ch   = chars[23 - 8 * i -: 8];
                e.last = (i == n_typed - 1);
                expected_chars.push_back(e);
            end
        end
        else
        begin
            for (i = 0; i < run_q.size(); i++)
            begin
                e.ch   = run_q[i];
                e.last = (i == run_q.size() - 1);
                expected_chars.push_back(e);
            end
        end
        // gap between bursts
        if (idle_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        in_byte     <= c;
        end_of_text <= eot;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    // stop sending and wait until every expected byte has come out
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, then read the mode register back
    task automatic write_then_read(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_MODE)
        begin
            mode_q = data[0];
            esc_q  = ESC_NONE;
            held_q = '0;
        end
        mode_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODE;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {31'b0, mode_q})
        begin
            $error("prdata: expected %h, got %h", {31'b0, mode_q}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic row_t directed_row(input int i);
        row_t r;
        r = '0;
        case (i)
            // encode, reset mode
            0:  r = '{1'b0, MODE_ENCODE, 8'h41, 1'b0, 1'b1, 2'd1, 24'h410000};
            1:  r = '{1'b0, MODE_ENCODE, 8'h00, 1'b0, 1'b1, 2'd3, 24'h253030};
            2:  r = '{1'b0, MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 2'd3, 24'h254646};
            3:  r = '{1'b0, MODE_ENCODE, 8'h80, 1'b0, 1'b1, 2'd3, 24'h253830};
            4:  r = '{1'b0, MODE_ENCODE, CH_STAR, 1'b0, 1'b0, 2'd0, 24'h0};
            5:  r = '{1'b0, MODE_ENCODE, CH_DASH, 1'b0, 1'b0, 2'd0, 24'h0};
            6:  r = '{1'b0, MODE_ENCODE, CH_DOT, 1'b0, 1'b0, 2'd0, 24'h0};
            7:  r = '{1'b0, MODE_ENCODE, CH_UNDER, 1'b0, 1'b0, 2'd0, 24'h0};
            8:  r = '{1'b0, MODE_ENCODE, 8'h7B, 1'b0, 1'b1, 2'd3, 24'h253742};
            9:  r = '{1'b0, MODE_ENCODE, CH_PERCENT, 1'b0, 1'b0, 2'd0, 24'h0};
            10: r = '{1'b0, MODE_ENCODE, CH_PLUS, 1'b1, 1'b0, 2'd0, 24'h0};
            // decode: plus, full escape with lower-case digit
            11: r = '{1'b1, MODE_DECODE, CH_PLUS, 1'b0, 1'b1, 2'd1, 24'h200000};
            12: r = '{1'b0, MODE_DECODE, CH_PERCENT, 1'b0, 1'b1, 2'd0, 24'h0};
            13: r = '{1'b0, MODE_DECODE, 8'h34, 1'b0, 1'b1, 2'd0, 24'h0};
            14: r = '{1'b0, MODE_DECODE, 8'h66, 1'b0, 1'b1, 2'd1, 24'h4F0000};
            // broken after a digit keeps the digit's case
            15: r = '{1'b0, MODE_DECODE, CH_PERCENT, 1'b0, 1'b1, 2'd0, 24'h0};
            16: r = '{1'b0, MODE_DECODE, 8'h61, 1'b0, 1'b1, 2'd0, 24'h0};
            17: r = '{1'b0, MODE_DECODE, 8'h47, 1'b0, 1'b1, 2'd3, 24'h256147};
            // percent after percent restarts, then flush at end of text
            18: r = '{1'b0, MODE_DECODE, CH_PERCENT, 1'b0, 1'b1, 2'd0, 24'h0};
            19: r = '{1'b0, MODE_DECODE, CH_PERCENT, 1'b0, 1'b1, 2'd1, 24'h250000};
            20: r = '{1'b0, MODE_DECODE, 8'h42, 1'b1, 1'b1, 2'd2, 24'h254200};
            // mode write drops a pending escape
            21: r = '{1'b0, MODE_DECODE, CH_PERCENT, 1'b0, 1'b1, 2'd0, 24'h0};
            22: r = '{1'b1, MODE_DECODE, 8'h34, 1'b0, 1'b1, 2'd1, 24'h340000};
            23: r = '{1'b0, MODE_DECODE, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0};
            default: r = '{1'b0, MODE_DECODE, 8'hFF, 1'b1, 1'b0, 2'd0, 24'h0};
        endcase
        return r;
    endfunction

    // one decode sequence: a random byte, a plus, or a well formed or broken escape
    task automatic decode_sequence();
        int k;
        logic eot;
        k   = $urandom_range(0, 99);
        eot = ($urandom_range(0, 11) == 0);
        if (k < 30)
        begin
            offer(8'($urandom_range(0, 255)), eot);
        end
        else if (k < 40)
        begin
            offer(CH_PLUS, eot);
        end
        else if (k < 75)
        begin
            offer(CH_PERCENT, 1'b0);
            offer(random_hex_char(), 1'b0);
            offer(random_hex_char(), eot);
        end
        else if (k < 85)
        begin
            offer(CH_PERCENT, 1'b0);
            offer(random_non_hex(), eot);
        end
        else if (k < 95)
        begin
            offer(CH_PERCENT, 1'b0);
            offer(random_hex_char(), 1'b0);
            offer(random_non_hex(), eot);
        end
        else if (k < 97)
        begin
            offer(CH_PERCENT, 1'b1);
        end
        else
        begin
            offer(CH_PERCENT, 1'b0);
            offer(random_hex_char(), 1'b1);
        end
    endtask

    // stimulus
    initial
    begin
        int i;
        int target;
        row_t row;
        logic m;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write to an unused address must leave the mode alone
        write_then_read(ADDR_SPARE, 32'h1);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_row(i);
            if (row.wr_mode)
            begin
                drain_block();
                write_then_read(ADDR_MODE, 32'(row.mode));
            end
            offer(row.ch, row.eot, row.typed, row.n, row.chars);
        end

        // random phases, each with its own mode setting
        while (items_sent < N_DIRECTED + RANDOM_ITEMS)
        begin
            drain_block();
            if (phases == 0)
                m = MODE_ENCODE;
            else if (phases == 1)
                m = MODE_DECODE;
            else
                m = ($urandom_range(0, 2) != 0) ? MODE_DECODE : MODE_ENCODE;
            write_then_read(ADDR_MODE, 32'(m));
            idle_on    = (phases % 4 != 2);
            burst_left = 0;
            if (phases == 2 || phases == 5)
                hold_reqs <= hold_reqs + 1;
            target = items_sent + $urandom_range(15, 35);
            while (items_sent < target)
            begin
                if (m == MODE_DECODE)
                    decode_sequence();
                else if ($urandom_range(0, 3) == 0)
                    offer(ENC_EDGES[4'($urandom_range(0, 15))], $urandom_range(0, 9) == 0);
                else
                    offer(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            phases++;
        end

        drain_block();
        $display("sent %0d input bytes over %0d random phases, checked %0d output bytes",
                 items_sent, phases, results_seen);
        $display("%0d register writes, %0d cycles with the input held off",
                 mode_writes, input_holds);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver stall pattern, with long hold-offs on request
    initial
    begin
        int seg_left;
        int style;
        int hold_seen;
        int hold_left;
        seg_left  = 0;
        style     = 0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(8, 48);
                    style    = $urandom_range(0, 3);
                end
                seg_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_stall)
            input_holds++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("out_byte: no transaction expected, got %h", out_byte);
                errors++;
            end
            else
            begin
                head = expected_chars.pop_front();
                results_seen++;
                if (out_byte !== head.ch)
                begin
                    $error("out_byte: expected %h, got %h", head.ch, out_byte);
                    errors++;
                end
                if (last_of_run !== head.last)
                begin
                    $error("last_of_run: expected %b, got %b", head.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("timed out after %0d cycles", cycles);
        $display("FAIL");
        $finish;
    end

endmodule
